// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros used by the top-level averager
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/epva_pkg.sv =====
// ----------------------------------------------------------------------------
// epva_pkg
// shared widths, codes and types of the encoder velocity averager
// ----------------------------------------------------------------------------
package epva_pkg;

   // field and register widths
   localparam int SCALE_W    = 48;
   localparam int TIMEOUT_W  = 32;
   localparam int VEL_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 48;

   // default window depth
   localparam int WINDOW_DEF = 8;

   // register reset values
   localparam logic [SCALE_W-1:0]   SCALE_RESET   = 48'd1000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd100000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'd1;

   // operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   // previous line level codes
   localparam logic [1:0] LEVEL_LOW  = 2'd0;
   localparam logic [1:0] LEVEL_HIGH = 2'd1;
   localparam logic [1:0] LEVEL_NONE = 2'd2;

   // serial divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== src/epva_if.sv =====
// ----------------------------------------------------------------------------
// epva_req_if / epva_rsp_if
// valid/ready channels for encoder words and velocity words
// ----------------------------------------------------------------------------
interface epva_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic level;

   modport source (output valid, output operation, output level, input ready);
   modport sink   (input valid, input operation, input level, output ready);
endinterface

interface epva_rsp_if import epva_pkg::*;;
   logic             valid;
   logic             ready;
   logic [VEL_W-1:0] velocity;
   logic             timed_out;

   modport source (output valid, output velocity, output timed_out, input ready);
   modport sink   (input valid, input velocity, input timed_out, output ready);
endinterface

// ===== src/epva_serial_div.sv =====
// ----------------------------------------------------------------------------
// epva_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module epva_serial_div import epva_pkg::*; #(
   parameter int NUM_W = SCALE_W,
   parameter int DEN_W = TIMEOUT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output div_status_type   status,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;

   // one shift and trial subtract per cycle
   assign shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = numerator;
         den_in   = denominator;
         count_in = CNT_W'(NUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== src/epva_window.sv =====
// ----------------------------------------------------------------------------
// epva_window
// sample shift line with running sum, updated by a subtract step and then an add step per push
// ----------------------------------------------------------------------------
module epva_window import epva_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF,
   parameter int SUM_W  = VEL_W + $clog2(WINDOW)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [VEL_W-1:0] sample,
   output logic             busy,
   output logic [SUM_W-1:0] sum
);

   logic [VEL_W-1:0] win_ff [WINDOW];
   logic [VEL_W-1:0] win_in [WINDOW];
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             add_ff, add_in;

   // push drops the oldest sample from the sum, the next cycle adds the new one
   always_comb begin
      win_in = win_ff;
      sum_in = sum_ff;
      add_in = 1'b0;
      if (push) begin
         sum_in = sum_ff - SUM_W'(win_ff[WINDOW-1]);
         for (int i = 1; i < WINDOW; i++) begin
            win_in[i] = win_ff[i-1];
         end
         win_in[0] = sample;
         add_in    = 1'b1;
      end else if (add_ff) begin
         sum_in = sum_ff + SUM_W'(win_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff <= '0;
         add_ff <= 1'b0;
      end else begin
         win_ff <= win_in;
         sum_ff <= sum_in;
         add_ff <= add_in;
      end
   end

   assign busy = add_ff;
   assign sum  = sum_ff;

endmodule

// ===== src/encoder_pulse_velocity_averager.sv =====
// ----------------------------------------------------------------------------
// encoder_pulse_velocity_averager
// edge period to velocity, averaged over a sliding window of samples
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  req_ch   | in  | valid / ready        | operation, level
//  rsp_ch   | out | valid / ready        | velocity, timed_out
//  csr_*    | in  | csr_we, no back-pres | csr_index, csr_wdata
//
//  a tick passes ST_TICK and ST_FINISH, an edge without a new sample only ST_FINISH,
//  an edge with a sample ST_DIV_SAMPLE, ST_PUSH, ST_WIN_WAIT, ST_DIV_MEAN and ST_FINISH
//  (two passes of the bit-serial divider: period division, then window mean), a zero
//  period all of them but ST_DIV_SAMPLE; one word at a time; the output register lets
//  the next word in while a result waits; a stalled result holds the block in its final state
//  synchronous active-high reset clears the window, sum and counters
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module encoder_pulse_velocity_averager import epva_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   epva_req_if.sink              req_ch,
   epva_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W = VEL_W + $clog2(WINDOW);

   // sequencer states
   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_TICK       = 3'd1;
   localparam logic [2:0] ST_DIV_SAMPLE = 3'd2;
   localparam logic [2:0] ST_PUSH       = 3'd3;
   localparam logic [2:0] ST_WIN_WAIT   = 3'd4;
   localparam logic [2:0] ST_DIV_MEAN   = 3'd5;
   localparam logic [2:0] ST_FINISH     = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [TIMEOUT_W-1:0] elapsed_ff, elapsed_in;
   logic [1:0]           prev_level_ff, prev_level_in;
   logic                 stalled_ff, stalled_in;
   logic [VEL_W-1:0]     vel_out_ff, vel_out_in;
   logic [VEL_W-1:0]     mean_ff, mean_in;
   logic [VEL_W-1:0]     sample_ff, sample_in;
   logic                 out_valid_ff, out_valid_in;
   logic [VEL_W-1:0]     out_vel_ff, out_vel_in;
   logic                 out_to_ff, out_to_in;

   logic                 accept;
   logic                 div_start;
   logic [SCALE_W-1:0]   div_num;
   logic [TIMEOUT_W-1:0] div_den;
   div_status_type       div_status;
   logic [SCALE_W-1:0]   div_quo;
   logic                 win_push;
   logic                 win_busy;
   logic [SUM_W-1:0]     win_sum;
   logic [VEL_W-1:0]     quo_sat;

   epva_serial_div #(
      .NUM_W (SCALE_W),
      .DEN_W (TIMEOUT_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .status      (div_status),
      .quotient    (div_quo)
   );

   epva_window #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_win (
      .clock  (clock),
      .reset  (reset),
      .push   (win_push),
      .sample (sample_ff),
      .busy   (win_busy),
      .sum    (win_sum)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && (state_ff == ST_IDLE);

   // quotient clipped to the output range
   assign quo_sat = (div_quo[SCALE_W-1:VEL_W] != '0) ? '1 : div_quo[VEL_W-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      scale_in      = scale_ff;
      timeout_in    = timeout_ff;
      elapsed_in    = elapsed_ff;
      prev_level_in = prev_level_ff;
      stalled_in    = stalled_ff;
      vel_out_in    = vel_out_ff;
      mean_in       = mean_ff;
      sample_in     = sample_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_vel_in    = out_vel_ff;
      out_to_in     = out_to_ff;
      div_start     = 1'b0;
      div_num       = scale_ff;
      div_den       = elapsed_ff;
      win_push      = 1'b0;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_SCALE:   scale_in   = csr_wdata[SCALE_W-1:0];
            CSR_TIMEOUT: timeout_in = csr_wdata[TIMEOUT_W-1:0];
            default:     ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.operation == OP_TICK) begin
                  if (elapsed_ff != '1) begin
                     elapsed_in = elapsed_ff + TIMEOUT_W'(1);
                  end
                  state_in = ST_TICK;
               end else begin
                  prev_level_in = {1'b0, req_ch.level};
                  elapsed_in    = '0;
                  stalled_in    = 1'b0;
                  if (prev_level_ff == LEVEL_HIGH) begin
                     if (elapsed_ff == '0) begin
                        sample_in = '0;
                        state_in  = ST_PUSH;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV_SAMPLE;
                     end
                  end else begin
                     vel_out_in = mean_ff;
                     state_in   = ST_FINISH;
                  end
               end
            end
         end
         ST_TICK: begin
            if (!stalled_ff && (elapsed_ff >= timeout_ff)) begin
               vel_out_in = '0;
               stalled_in = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_DIV_SAMPLE: begin
            if (div_status.done) begin
               sample_in = quo_sat;
               state_in  = ST_PUSH;
            end
         end
         ST_PUSH: begin
            win_push = 1'b1;
            state_in = ST_WIN_WAIT;
         end
         ST_WIN_WAIT: begin
            if (!win_busy) begin
               div_start = 1'b1;
               div_num   = SCALE_W'(win_sum);
               div_den   = TIMEOUT_W'(WINDOW);
               state_in  = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (div_status.done) begin
               mean_in    = div_quo[VEL_W-1:0];
               vel_out_in = div_quo[VEL_W-1:0];
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_vel_in   = vel_out_ff;
               out_to_in    = stalled_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      out_vel_ff <= out_vel_in;
      out_to_ff  <= out_to_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         scale_ff      <= SCALE_RESET;
         timeout_ff    <= TIMEOUT_RESET;
         elapsed_ff    <= '0;
         prev_level_ff <= LEVEL_NONE;
         stalled_ff    <= 1'b0;
         vel_out_ff    <= '0;
         mean_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scale_ff      <= scale_in;
         timeout_ff    <= timeout_in;
         elapsed_ff    <= elapsed_in;
         prev_level_ff <= prev_level_in;
         stalled_ff    <= stalled_in;
         vel_out_ff    <= vel_out_in;
         mean_ff       <= mean_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.velocity  = out_vel_ff;
   assign rsp_ch.timed_out = out_to_ff;

   // checks
   `ASSERT_NEVER(a_div_restart, clock, reset, div_start && div_status.busy,
      "divider started while busy")
   `ASSERT_NEVER(a_ready_busy, clock, reset, req_ch.ready && (div_status.busy || win_busy),
      "word accepted while arithmetic is in flight")
   `ASSERT_HOLDS(a_timeout_zero, clock, reset,
      (rsp_ch.valid && rsp_ch.timed_out) |-> (rsp_ch.velocity == '0),
      "timed out result with nonzero velocity")
   `ASSERT_HOLDS(a_push_then_idle_div, clock, reset,
      win_push |=> (state_ff == ST_WIN_WAIT && !div_status.busy),
      "window push overlapped a division")

endmodule
